FILE: rtl/nbmu_pkg.sv
// Shared types, constants and functions of the sigmoid neuron backprop unit.
`default_nettype none

package nbmu_pkg;

    typedef longint unsigned u64_t;
    typedef longint          s64_t;

    localparam int MAX_INPUTS = 64;
    localparam int ADDR_W     = $clog2(MAX_INPUTS);
    localparam int SIG_SIZE   = 256;
    localparam int SIG_IDX_W  = $clog2(SIG_SIZE);
    localparam int ACT_W      = 13;    // activation is 0..4096
    localparam int CFG_W      = 13;
    localparam int ACC_W      = 40;
    localparam int MUL_A_W    = 30;
    localparam int MUL_B_W    = 26;
    localparam int PROD_W     = 56;
    localparam int SUM_W      = 48;
    localparam int Q_ONE      = 4096;

    localparam u64_t ONE_Q32    = 64'd4294967296;
    localparam u64_t EXP_M1_Q32 = 64'd1580030169;

    // command codes
    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_FWD   = 3'd1,
        CMD_OGRAD = 3'd2,
        CMD_HID   = 3'd3,
        CMD_UPD   = 3'd4
    } cmd_t;

    // config register indexes
    typedef enum logic {
        CFG_LEARN_RATE = 1'b0,
        CFG_MOMENTUM   = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_MULW, S_MULB, S_ACC, S_RND, S_SIG, S_OG,
        S_D1, S_D2, S_GRAD, S_U1, S_U2, S_U3, S_U4, S_U5, S_NOP
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_MUL_AW, OP_MUL_AB, OP_ACC, OP_RND, OP_SIG, OP_OG,
        OP_D1, OP_D2, OP_GRAD, OP_U1, OP_U2, OP_U3, OP_U4, OP_U5, OP_NOP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
        logic   emit;
    } dp_ctrl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       last;
    } dp_stat_t;

    typedef struct packed {
        logic signed [15:0] v;
        logic               clip;
    } sat_t;

    // clip to Q4.12
    function automatic sat_t sat16(input logic signed [PROD_W-1:0] v);
        sat_t r;
        r.clip = 1'b1;
        if (v > PROD_W'(32767)) begin
            r.v = 16'sh7FFF;
        end else if (v < -PROD_W'(32768)) begin
            r.v = 16'sh8000;
        end else begin
            r.v    = v[15:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // shift-subtract divide, elaboration use only
    function automatic u64_t udiv64(input u64_t num, input u64_t den);
        u64_t q;
        u64_t r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-t), t in Q16, result Q32; fraction by 12-term series
    function automatic u64_t exp_neg_q32(input u64_t t);
        u64_t ip;
        u64_t r;
        u64_t mag;
        s64_t fp;
        s64_t term;
        s64_t sum;
        s64_t x;
        ip   = t >> 16;
        fp   = s64_t'(t & 64'hFFFF);
        term = s64_t'(ONE_Q32);
        sum  = s64_t'(ONE_Q32);
        for (int n = 1; n <= 12; n++) begin
            x    = (-term) * fp;
            mag  = (x < 0) ? u64_t'(-x) : u64_t'(x);
            mag  = udiv64(mag >> 16, u64_t'(n));
            term = (x < 0) ? -s64_t'(mag) : s64_t'(mag);
            sum  = sum + term;
        end
        r = u64_t'(sum);
        for (u64_t i = 0; i < ip; i++) begin
            r = (r * EXP_M1_Q32) >> 32;
        end
        return r;
    endfunction

    typedef logic [ACT_W-1:0] sig_tab_t [SIG_SIZE];

    function automatic sig_tab_t build_sig_table();
        sig_tab_t tab;
        s64_t     x;
        u64_t     t;
        u64_t     e;
        u64_t     den;
        u64_t     num;
        for (int k = 0; k < SIG_SIZE; k++) begin
            x   = -(s64_t'(1) << 19) + ((2 * s64_t'(k) + 1) * (s64_t'(1) << 19)) / SIG_SIZE;
            t   = (x < 0) ? u64_t'(-x) : u64_t'(x);
            e   = exp_neg_q32(t);
            den = ONE_Q32 + e;
            num = (x >= 0) ? (u64_t'(4096) << 32) : u64_t'(4096) * e;
            tab[k] = ACT_W'(udiv64(num + (den >> 1), den));
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

FILE: rtl/nbmu_ctrl.sv
// Command sequencer of the neuron unit.
`default_nettype none

module nbmu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        command,
    input  wire nbmu_pkg::dp_stat_t stat,
    output nbmu_pkg::dp_ctrl_t     ctrl,
    output logic                   busy
);
    import nbmu_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        ctrl.op     = OP_IDLE;
        ctrl.accept = 1'b0;
        ctrl.emit   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    ctrl.accept = 1'b1;
                    unique case (command)
                        CMD_LOAD:  state_next = S_LOAD;
                        CMD_FWD:   state_next = S_MULW;
                        CMD_OGRAD: state_next = S_OG;
                        CMD_HID:   state_next = S_MULB;
                        CMD_UPD:   state_next = S_U1;
                        default:   state_next = S_NOP;
                    endcase
                end
            end
            S_LOAD: begin
                ctrl.op    = OP_LOAD;
                ctrl.emit  = 1'b1;
                state_next = S_IDLE;
            end
            S_MULW: begin
                ctrl.op    = OP_MUL_AW;
                state_next = S_ACC;
            end
            S_MULB: begin
                ctrl.op    = OP_MUL_AB;
                state_next = S_ACC;
            end
            S_ACC: begin
                ctrl.op = OP_ACC;
                if (stat.last) begin
                    state_next = S_RND;
                end else begin
                    ctrl.emit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RND: begin
                ctrl.op    = OP_RND;
                state_next = (stat.cmd == CMD_FWD) ? S_SIG : S_D1;
            end
            S_SIG: begin
                ctrl.op    = OP_SIG;
                ctrl.emit  = 1'b1;
                state_next = S_IDLE;
            end
            S_OG: begin
                ctrl.op    = OP_OG;
                state_next = S_D1;
            end
            S_D1: begin
                ctrl.op    = OP_D1;
                state_next = S_D2;
            end
            S_D2: begin
                ctrl.op    = OP_D2;
                state_next = S_GRAD;
            end
            S_GRAD: begin
                ctrl.op    = OP_GRAD;
                ctrl.emit  = 1'b1;
                state_next = S_IDLE;
            end
            S_U1: begin
                ctrl.op    = OP_U1;
                state_next = S_U2;
            end
            S_U2: begin
                ctrl.op    = OP_U2;
                state_next = S_U3;
            end
            S_U3: begin
                ctrl.op    = OP_U3;
                state_next = S_U4;
            end
            S_U4: begin
                ctrl.op    = OP_U4;
                state_next = S_U5;
            end
            S_U5: begin
                ctrl.op    = OP_U5;
                ctrl.emit  = 1'b1;
                state_next = S_IDLE;
            end
            S_NOP: begin
                ctrl.op    = OP_NOP;
                ctrl.emit  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/nbmu_dpath.sv
// Datapath: weight/delta memories, shared multiplier, accumulator, sigmoid table.
`default_nettype none

module nbmu_dpath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire nbmu_pkg::dp_ctrl_t  ctrl,
    output nbmu_pkg::dp_stat_t       stat,
    input  wire logic [2:0]          command,
    input  wire logic signed [15:0]  operand_a,
    input  wire logic signed [15:0]  operand_b,
    input  wire logic [5:0]          weight_index,
    input  wire logic                last,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [12:0]         cfg_data,
    output logic                     done,
    output logic signed [15:0]       result_value,
    output logic                     result_final,
    output logic                     saturated
);
    import nbmu_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // captured request
    logic [2:0]         cmd_reg;
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic               last_reg;

    logic signed [15:0] weight_mem [MAX_INPUTS];
    logic signed [15:0] delta_mem  [MAX_INPUTS];
    logic [MAX_INPUTS-1:0] dvld_reg;
    logic signed [15:0] w_rd_reg;
    logic signed [15:0] dl_rd_reg;
    logic               dvld_rd_reg;

    logic [CFG_W-1:0]   lr_reg;
    logic [CFG_W-1:0]   mom_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [16:0]       d_reg;
    logic [ACT_W-1:0]         act_reg;
    logic signed [15:0]       grad_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [15:0]       nd_reg;
    logic                     sat_reg;

    logic                     done_reg;
    logic signed [15:0]       val_reg;
    logic                     fin_reg;
    logic                     sato_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [13:0]               act_c;
    logic signed [ACC_W:0]     acc_sum;
    logic                      acc_ovf;
    logic signed [ACC_W-1:0]   acc_new;
    logic signed [ACC_W:0]     acc_rnd;
    logic signed [SUM_W-1:0]   upd_sum;
    logic [15:0]               sig_u;
    logic [ACT_W-1:0]          act_new;
    logic signed [16:0]        og_d;
    sat_t                      rnd_s;
    sat_t                      grad_s;
    sat_t                      nd_s;
    sat_t                      w_s;
    logic                      sat_now;
    logic                      sat_any;
    logic signed [15:0]        emit_val;

    assign stat.cmd  = cmd_reg;
    assign stat.last = last_reg;

    // shared multiplier operand select
    assign act_c = 14'(Q_ONE) - {1'b0, act_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.op)
            OP_MUL_AW: begin
                mul_a = MUL_A_W'(a_reg);
                mul_b = MUL_B_W'(w_rd_reg);
            end
            OP_MUL_AB: begin
                mul_a = MUL_A_W'(a_reg);
                mul_b = MUL_B_W'(b_reg);
            end
            OP_D1: begin
                mul_a = MUL_A_W'($signed({1'b0, act_reg}));
                mul_b = MUL_B_W'($signed({1'b0, act_c}));
            end
            OP_D2: begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = $signed(prod_reg[MUL_B_W-1:0]);
            end
            OP_U1: begin
                mul_a = MUL_A_W'($signed({1'b0, lr_reg}));
                mul_b = MUL_B_W'(a_reg);
            end
            OP_U2: begin
                mul_a = $signed(prod_reg[MUL_A_W-1:0]);
                mul_b = MUL_B_W'(grad_reg);
            end
            OP_U3: begin
                mul_a = MUL_A_W'($signed({1'b0, mom_reg}));
                mul_b = MUL_B_W'(dl_rd_reg);
            end
            default: ;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // accumulate with 40-bit clip
    assign acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'($signed(prod_reg[31:0]));
    assign acc_ovf = acc_sum[ACC_W] ^ acc_sum[ACC_W-1];
    assign acc_new = acc_ovf ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];

    assign acc_rnd = ((ACC_W+1)'(acc_reg) + (ACC_W+1)'(2048)) >>> 12;
    assign rnd_s   = sat16(PROD_W'(acc_rnd));

    // table index = (s + 32768) * SIZE >> 16
    assign sig_u   = {~d_reg[15], d_reg[14:0]};
    assign act_new = SIG_TABLE[sig_u[15 -: SIG_IDX_W]];

    assign og_d   = 17'(a_reg) - $signed({4'b0, act_reg});
    assign grad_s = sat16((prod_reg + PROD_W'(64'sd8388608)) >>> 24);

    assign upd_sum = sum_reg + (SUM_W'($signed(prod_reg[MUL_A_W-1:0])) <<< 12);
    assign nd_s    = sat16(PROD_W'((upd_sum + SUM_W'(64'sd8388608)) >>> 24));
    assign w_s     = sat16(PROD_W'(w_rd_reg) + PROD_W'(nd_reg));

    always_comb begin
        unique case (ctrl.op)
            OP_ACC:  sat_now = acc_ovf;
            OP_RND:  sat_now = rnd_s.clip;
            OP_GRAD: sat_now = grad_s.clip;
            OP_U4:   sat_now = nd_s.clip;
            OP_U5:   sat_now = w_s.clip;
            default: sat_now = 1'b0;
        endcase
    end
    assign sat_any = sat_reg | sat_now;

    always_comb begin
        unique case (ctrl.op)
            OP_SIG:  emit_val = 16'($signed({1'b0, act_new}));
            OP_GRAD: emit_val = grad_s.v;
            OP_U5:   emit_val = w_s.v;
            default: emit_val = '0;
        endcase
    end

    // request capture and read of both stores
    always_ff @(posedge clk) begin
        if (ctrl.accept) begin
            cmd_reg     <= command;
            a_reg       <= operand_a;
            b_reg       <= operand_b;
            idx_reg     <= weight_index[ADDR_W-1:0];
            last_reg    <= last;
            w_rd_reg    <= weight_mem[weight_index[ADDR_W-1:0]];
            dl_rd_reg   <= delta_mem[weight_index[ADDR_W-1:0]];
            dvld_rd_reg <= dvld_reg[weight_index[ADDR_W-1:0]];
        end else if (ctrl.op == OP_MUL_AW && !dvld_rd_reg) begin
            dl_rd_reg <= '0;
        end else if (ctrl.op == OP_U1 && !dvld_rd_reg) begin
            dl_rd_reg <= '0;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.op == OP_LOAD) begin
            weight_mem[idx_reg] <= a_reg;
        end else if (ctrl.op == OP_U5) begin
            weight_mem[idx_reg] <= w_s.v;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.op == OP_U4) begin
            delta_mem[idx_reg] <= nd_s.v;
        end
    end

    // working registers without reset
    always_ff @(posedge clk) begin
        unique case (ctrl.op)
            OP_RND:  d_reg <= 17'(rnd_s.v);
            OP_OG:   d_reg <= og_d;
            default: ;
        endcase
        if (ctrl.op == OP_MUL_AW || ctrl.op == OP_MUL_AB || ctrl.op == OP_D1 ||
            ctrl.op == OP_D2 || ctrl.op == OP_U1 || ctrl.op == OP_U2 ||
            ctrl.op == OP_U3) begin
            prod_reg <= mul_p;
        end
        if (ctrl.op == OP_U3) begin
            sum_reg <= prod_reg[SUM_W-1:0];
        end
        if (ctrl.op == OP_U4) begin
            nd_reg <= nd_s.v;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dvld_reg <= '0;
            lr_reg   <= CFG_W'(614);
            mom_reg  <= CFG_W'(2048);
            acc_reg  <= '0;
            act_reg  <= '0;
            grad_reg <= '0;
            sat_reg  <= 1'b0;
            done_reg <= 1'b0;
            val_reg  <= '0;
            fin_reg  <= 1'b0;
            sato_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_LEARN_RATE: lr_reg  <= cfg_data;
                    CFG_MOMENTUM:   mom_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ctrl.op == OP_LOAD) begin
                dvld_reg[idx_reg] <= 1'b0;
            end else if (ctrl.op == OP_U4) begin
                dvld_reg[idx_reg] <= 1'b1;
            end
            if (ctrl.op == OP_ACC) begin
                acc_reg <= acc_new;
            end else if (ctrl.op == OP_RND) begin
                acc_reg <= '0;
            end
            if (ctrl.op == OP_SIG) begin
                act_reg <= act_new;
            end
            if (ctrl.op == OP_GRAD) begin
                grad_reg <= grad_s.v;
            end
            sat_reg  <= ctrl.accept ? 1'b0 : sat_any;
            done_reg <= ctrl.emit;
            if (ctrl.emit) begin
                val_reg  <= emit_val;
                fin_reg  <= (ctrl.op == OP_SIG || ctrl.op == OP_GRAD || ctrl.op == OP_U5);
                sato_reg <= sat_any;
            end else begin
                val_reg  <= '0;
                fin_reg  <= 1'b0;
                sato_reg <= 1'b0;
            end
        end
    end

    assign done         = done_reg;
    assign result_value = val_reg;
    assign result_final = fin_reg;
    assign saturated    = sato_reg;

endmodule

`default_nettype wire

FILE: rtl/neuron_backprop_momentum_unit.sv
// Top level of the sigmoid neuron backprop unit: sequencer plus datapath.
`default_nettype none

// One sigmoid neuron with 64 stored Q4.12 weights and their last deltas.
// A request is taken when start is high and busy is low; every request
// yields exactly one result, shown for one cycle with done high, during
// the first cycle that busy is low again. The receiver cannot stall the
// unit, so sample result_value, result_final and saturated whenever done
// is high.
// Sequencer steps per request, in order, all set by one shared 30x26 multiplier and the
// one-port weight/delta memories:
//   load or unused command ........ load or no-op
//   forward/hidden element, not last multiply, accumulate
//   forward, last element .......... multiply, accumulate, round, table
//   output gradient ................ difference, a(1-a), product, round
//   hidden, last element ........... mul, acc, round, a(1-a), product, round
//   weight update .................. lr*a, *g, mom*delta, sum, write
// Forward and hidden runs share one accumulator; do not interleave them.
// Configuration writes (cfg_index 0 learning rate, 1 momentum, Q1.12) are
// always ready and should only be issued while the unit is idle. No
// clearing pass is needed after reset: delta entries carry valid bits.

module neuron_backprop_momentum_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         command,
    input  wire logic signed [15:0] operand_a,
    input  wire logic signed [15:0] operand_b,
    input  wire logic [5:0]         weight_index,
    input  wire logic               last,
    output logic                    done,
    output logic signed [15:0]      result_value,
    output logic                    result_final,
    output logic                    saturated,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [12:0]        cfg_data
);
    import nbmu_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // configuration writes are always accepted
    assign cfg_ready = 1'b1;

    nbmu_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    nbmu_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .command      (command),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .weight_index (weight_index),
        .last         (last),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .result_value (result_value),
        .result_final (result_final),
        .saturated    (saturated)
    );

    // accepted request always occupies the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // one result per request, never two in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_partial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result_final) |-> (result_value == 16'sd0))
        else $error("unfinished result carries a value");

    a_final_marked: assert property (@(posedge clk) disable iff (!rst_n)
        result_final |-> done)
        else $error("result_final without done");

endmodule

`default_nettype wire
